[rtl/sdrd_pkg.sv]
// ----------------------------------------------------------------------------
// sdrd_pkg
// Types, constants and helpers shared by the signed difference radix digit
// unit: payload structs, controller states, command and status groups.
// ----------------------------------------------------------------------------
package sdrd_pkg;

    localparam int OPERAND_W = 32;
    localparam int RADIX_W   = 6;
    localparam int CHAR_W    = 7;
    localparam int DIGIT_W   = 6;
    // dividend bits retired per divider cycle
    localparam int STEP_BITS = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS  = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    typedef struct packed {
        logic [OPERAND_W-1:0] minuend;
        logic [OPERAND_W-1:0] subtrahend;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last_char;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic sign_out;
        logic pop_out;
    } cmd_t;

    typedef struct packed {
        logic step_last;
        logic quot_zero;
        logic negative;
        logic one_left;
        logic out_free;
    } sts_t;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] v);
        logic [RADIX_W-1:0] r;
        if (v < RADIX_MIN) begin
            r = RADIX_MIN;
        end else if (v > RADIX_MAX) begin
            r = RADIX_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= DEC_DIGITS) begin
            c = CHAR_A + CHAR_W'(d - DEC_DIGITS);
        end else begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

[rtl/signed_difference_radix_digits_unit.sv]
// Sequence: accept, then one division per digit until the quotient is zero,
// then any sign and the digits into the output register, one per cycle when free.
// One item at a time: a new pair is accepted only in idle, after the last character
// is loaded; the shared divider retires 8 dividend bits per cycle.
// Reset (aresetn low, synchronous): controller idle, output empty, radix back to 10.
// ----------------------------------------------------------------------------
// signed_difference_radix_digits_unit
// Writes minuend - subtrahend as ASCII digits in a programmable radix,
// with a leading '-' for negative differences, one character per transfer.
// ----------------------------------------------------------------------------
module signed_difference_radix_digits_unit
    import sdrd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [RADIX_W-1:0] cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_t                s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output out_t               m_payload
);

    logic [RADIX_W-1:0] radix_reg;
    cmd_t               cmd;
    sts_t               sts;

    assign cfg_ready = 1'b1;

    // radix is held already clamped to the legal range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_valid) begin
            radix_reg <= clamp_radix(cfg_data);
        end
    end

    sdrd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sdrd_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_payload),
        .radix     (radix_reg),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_payload)
    );

endmodule

[rtl/sdrd_ctrl.sv]
// ----------------------------------------------------------------------------
// sdrd_ctrl
// Sequencer: accepts an operand pair, runs the digit divisions, then
// emits the optional sign and the digits most significant first.
// ----------------------------------------------------------------------------
module sdrd_ctrl
    import sdrd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  sts_t   sts,
    output cmd_t   cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (sts.step_last && sts.quot_zero) begin
                    state_next = sts.negative ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (sts.out_free) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free && sts.one_left) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DIV:  cmd.div_step = 1'b1;
            ST_SIGN: cmd.sign_out = sts.out_free;
            ST_EMIT: cmd.pop_out  = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

[rtl/sdrd_datapath.sv]
// ----------------------------------------------------------------------------
// sdrd_datapath
// Magnitude and sign of the difference, a shift-subtract divider retiring
// STEP_BITS dividend bits per cycle, a digit stack and the output register.
// ----------------------------------------------------------------------------
module sdrd_datapath
    import sdrd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  in_t                in_data,
    input  logic [RADIX_W-1:0] radix,
    input  cmd_t               cmd,
    output sts_t               sts,
    output logic               out_valid,
    input  logic               out_ready,
    output out_t               out_data
);

    localparam int STEPS   = (DATA_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int PW      = STEPS * STEP_BITS;
    localparam int STEP_CW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int DCNT_W  = $clog2(DATA_WIDTH + 1);
    localparam int STACK_W = DATA_WIDTH * DIGIT_W;

    logic [PW-1:0]         dvd_reg;
    logic [DIGIT_W-1:0]    rem_reg;
    logic [STEP_CW-1:0]    step_reg;
    logic                  neg_reg;
    logic [STACK_W-1:0]    stack_reg;
    logic [DCNT_W-1:0]     cnt_reg;
    logic                  out_valid_reg;
    out_t                  out_reg;

    logic [DATA_WIDTH-1:0] a_w, b_w, mag;
    logic                  neg;
    logic [PW-1:0]         dvd_next;
    logic [DIGIT_W-1:0]    rem_next;
    logic [STEP_BITS-1:0]  chunk, qbits;
    logic [DIGIT_W:0]      trial;
    logic                  step_last;

    assign a_w = DATA_WIDTH'(in_data.minuend);
    assign b_w = DATA_WIDTH'(in_data.subtrahend);
    assign neg = b_w > a_w;
    assign mag = neg ? (b_w - a_w) : (a_w - b_w);

    // one radix-2 long division step per dividend bit; remainder stays < radix
    always_comb begin
        chunk    = dvd_reg[PW-1 -: STEP_BITS];
        rem_next = rem_reg;
        qbits    = '0;
        trial    = '0;
        for (int i = STEP_BITS - 1; i >= 0; i--) begin
            trial = {rem_next, chunk[i]};
            if (trial >= {1'b0, radix}) begin
                qbits[i] = 1'b1;
                rem_next = DIGIT_W'(trial - {1'b0, radix});
            end else begin
                rem_next = trial[DIGIT_W-1:0];
            end
        end
        dvd_next = (dvd_reg << STEP_BITS) | PW'(qbits);
    end

    assign step_last = step_reg == STEP_CW'(STEPS - 1);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dvd_reg  <= PW'(mag);
            rem_reg  <= '0;
            step_reg <= '0;
            neg_reg  <= neg;
        end else if (cmd.div_step) begin
            dvd_reg <= dvd_next;
            if (step_last) begin
                rem_reg   <= '0;
                step_reg  <= '0;
                stack_reg <= (stack_reg << DIGIT_W) | STACK_W'(rem_next);
            end else begin
                rem_reg  <= rem_next;
                step_reg <= step_reg + 1'b1;
            end
        end else if (cmd.pop_out) begin
            stack_reg <= stack_reg >> DIGIT_W;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_step && step_last) begin
            cnt_reg <= cnt_reg + 1'b1;
        end else if (cmd.pop_out) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // output register: the next character loads as the held one transfers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.sign_out || cmd.pop_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sign_out) begin
            out_reg.character <= CHAR_MINUS;
            out_reg.last_char <= 1'b0;
        end else if (cmd.pop_out) begin
            out_reg.character <= digit_char(stack_reg[DIGIT_W-1:0]);
            out_reg.last_char <= cnt_reg == DCNT_W'(1);
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_reg;
    assign sts.step_last = step_last;
    assign sts.quot_zero = dvd_next == '0;
    assign sts.negative  = neg_reg;
    assign sts.one_left  = cnt_reg == DCNT_W'(1);
    assign sts.out_free  = !out_valid_reg || out_ready;

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop_out |-> cnt_reg != '0)
        else $error("digit pop from empty stack");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |-> !(cmd.sign_out || cmd.pop_out))
        else $error("output register overwritten before transfer");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step && step_last |-> cnt_reg < DCNT_W'(DATA_WIDTH))
        else $error("digit stack overflow");

endmodule
